@@ rtl/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MIPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define MIPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MIPD_ASSERT(lbl, clk, rstn, prop)
`define MIPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/mipd_pkg.sv @@
// ============================================================================
// mipd_pkg
// Constants and helpers for the minimum-image pair distance core.
// ============================================================================
package mipd_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int LAT_BITS       = 60;
    localparam int SQ_BITS        = 44;
    localparam int DIST_BITS      = 22;
    localparam int DISP_BITS      = 22;
    localparam int IDX_BITS       = 5;
    localparam int CFG_IDX_BITS   = 2;
    localparam int NUM_IMAGES     = 27;
    localparam int TREE_LEVELS    = 5;
    localparam int TREE_LEAVES    = 32;
    localparam int DISP_LIMIT     = 2097151;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LATTICE_A = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LATTICE_B = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LATTICE_C = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [SQ_BITS-1:0]   SQ_MAX   = {SQ_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
    localparam logic [IDX_BITS-1:0]  IDX_MAX  = 5'd26;

    // lattice multiplier (-1, 0, 1) of image n along lattice vector axis
    function automatic int lat_coef(int n, int axis);
        int m;
        m = (n <= 13) ? n - 1 : n;
        if (n == 0)
            return 0;
        case (axis)
            0:       return m / 9 - 1;
            1:       return (m / 3) % 3 - 1;
            default: return m % 3 - 1;
        endcase
    endfunction

endpackage

@@ rtl/min_image_pair_distance_core.sv @@
// ============================================================================
// min_image_pair_distance_core
// Minimum-image displacement of a point pair in a periodic lattice cell.
// ============================================================================
// One pair per clock unless the output stalls; one result per pair, in order.
// All 27 lattice images are evaluated in parallel lanes; the early-stop scan
// rule is resolved by per-lane eligibility masks and a 5-level registered
// minimum tree, followed by a one-bit-per-stage square root pipeline.
// The pipeline is made of 6 front stages, the 5 tree levels, the square root
// stages and the output register. Lattice writes reach the lanes through the
// configuration and offset registers; the threshold register is used directly.
module min_image_pair_distance_core
    import mipd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [LAT_BITS-1:0]           cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  first_x,
    input  logic signed [COORD_BITS-1:0]  first_y,
    input  logic signed [COORD_BITS-1:0]  first_z,
    input  logic signed [COORD_BITS-1:0]  second_x,
    input  logic signed [COORD_BITS-1:0]  second_y,
    input  logic signed [COORD_BITS-1:0]  second_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SQ_BITS-1:0]            squared_distance,
    output logic [DIST_BITS-1:0]          distance,
    output logic signed [DISP_BITS-1:0]   disp_x,
    output logic signed [DISP_BITS-1:0]   disp_y,
    output logic signed [DISP_BITS-1:0]   disp_z,
    output logic [IDX_BITS-1:0]           image_index
);

`include "assert_macros.svh"

    localparam int CB   = COORD_BITS;
    localparam int BW   = CB + 1;
    localparam int OW   = CB + 2;
    localparam int CW   = CB + 3;
    localparam int PW   = 2 * CW;
    localparam int SW   = PW + 2;
    localparam int QW   = (SW + 1) / 2;
    localparam int RW   = 2 * QW + 1;
    localparam int LXW  = (3 * CB > LAT_BITS) ? 3 * CB : LAT_BITS;
    localparam int CMPW = (SW > SQ_BITS) ? SW : SQ_BITS;
    localparam int DQW  = (QW > DIST_BITS) ? QW : DIST_BITS;
    localparam int DXW  = (CW > DISP_BITS) ? CW : DISP_BITS;
    localparam int NSTG = 6 + TREE_LEVELS + QW;

    localparam logic signed [DXW-1:0] DMAX = DXW'(DISP_LIMIT);
    localparam logic signed [DXW-1:0] DMIN = -DMAX - DXW'(1);

    typedef struct packed {
        logic                  v;
        logic [SW-1:0]         sq;
        logic [IDX_BITS-1:0]   idx;
        logic signed [CW-1:0]  dx;
        logic signed [CW-1:0]  dy;
        logic signed [CW-1:0]  dz;
    } node_t;

    function automatic logic signed [OW-1:0] term(int c, logic signed [CB-1:0] v);
        if (c > 0)
            return OW'(v);
        else if (c < 0)
            return -OW'(v);
        else
            return '0;
    endfunction

    function automatic node_t pick(node_t a, node_t b);
        if (b.v && (!a.v || b.sq < a.sq))
            return b;
        else
            return a;
    endfunction

    // configuration
    logic [LAT_BITS-1:0] lat_a_reg, lat_b_reg, lat_c_reg;
    logic [SQ_BITS-1:0]  thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_a_reg <= '0;
            lat_b_reg <= '0;
            lat_c_reg <= '0;
            thr_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LATTICE_A: lat_a_reg <= cfg_data;
                CFG_LATTICE_B: lat_b_reg <= cfg_data;
                CFG_LATTICE_C: lat_c_reg <= cfg_data;
                CFG_THRESHOLD: thr_reg   <= cfg_data[SQ_BITS-1:0];
            endcase
        end
    end

    logic [LXW-1:0] la_ext, lb_ext, lc_ext;
    assign la_ext = LXW'(lat_a_reg);
    assign lb_ext = LXW'(lat_b_reg);
    assign lc_ext = LXW'(lat_c_reg);

    logic signed [OW-1:0] off_next [NUM_IMAGES][3];
    logic signed [OW-1:0] off_reg  [NUM_IMAGES][3];

    for (genvar n = 0; n < NUM_IMAGES; n++)
    begin : g_off
        localparam int CA = lat_coef(n, 0);
        localparam int CBB = lat_coef(n, 1);
        localparam int CC = lat_coef(n, 2);
        for (genvar d = 0; d < 3; d++)
        begin : g_dim
            assign off_next[n][d] = term(CA, la_ext[d*CB +: CB])
                                  + term(CBB, lb_ext[d*CB +: CB])
                                  + term(CC, lc_ext[d*CB +: CB]);
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
    end

    // pipeline control
    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic            out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NSTG-2:0], in_valid};
            out_valid_reg <= vld_reg[NSTG-1];
        end
    end

    // front stages
    logic signed [CB-1:0] fa [3];
    logic signed [CB-1:0] sb [3];
    assign fa[0] = first_x;
    assign fa[1] = first_y;
    assign fa[2] = first_z;
    assign sb[0] = second_x;
    assign sb[1] = second_y;
    assign sb[2] = second_z;

    logic signed [BW-1:0] base_reg [3];
    logic signed [CW-1:0] cand_reg [NUM_IMAGES][3];
    logic signed [CW-1:0] cand3_reg [NUM_IMAGES][3];
    logic signed [CW-1:0] cand4_reg [NUM_IMAGES][3];
    logic signed [CW-1:0] cand5_reg [NUM_IMAGES][3];
    logic [PW-1:0]        prod_reg [NUM_IMAGES][3];
    logic [SW-1:0]        t_reg    [NUM_IMAGES];
    logic [SW-1:0]        t5_reg   [NUM_IMAGES];
    logic [NUM_IMAGES-1:0] lt_reg;
    logic                 gt0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 3; d++)
                base_reg[d] <= BW'(fa[d]) - BW'(sb[d]);
            for (int n = 0; n < NUM_IMAGES; n++)
            begin
                for (int d = 0; d < 3; d++)
                begin
                    cand_reg[n][d]  <= CW'(base_reg[d]) + CW'(off_reg[n][d]);
                    prod_reg[n][d]  <= PW'(cand_reg[n][d] * cand_reg[n][d]);
                    cand3_reg[n][d] <= cand_reg[n][d];
                    cand4_reg[n][d] <= cand3_reg[n][d];
                    cand5_reg[n][d] <= cand4_reg[n][d];
                end
                t_reg[n]  <= SW'(prod_reg[n][0]) + SW'(prod_reg[n][1])
                           + SW'(prod_reg[n][2]);
                t5_reg[n] <= t_reg[n];
                lt_reg[n] <= CMPW'(t_reg[n]) < CMPW'(thr_reg);
            end
            gt0_reg <= CMPW'(t_reg[0]) > CMPW'(thr_reg);
        end
    end

    // leaves: lane n is reachable only if no earlier image stopped the scan
    node_t leaf [TREE_LEAVES];

    for (genvar n = 0; n < TREE_LEAVES; n++)
    begin : g_leaf
        if (n < NUM_IMAGES)
        begin : g_lane
            localparam logic [NUM_IMAGES-1:0] LOWER =
                NUM_IMAGES'((64'd1 << n) - 64'd1) & ~NUM_IMAGES'(1);
            always_comb
            begin
                leaf[n].v   = (n == 0) ? 1'b1 : (gt0_reg && !(|(lt_reg & LOWER)));
                leaf[n].sq  = t5_reg[n];
                leaf[n].idx = IDX_BITS'(n);
                leaf[n].dx  = cand5_reg[n][0];
                leaf[n].dy  = cand5_reg[n][1];
                leaf[n].dz  = cand5_reg[n][2];
            end
        end
        else
        begin : g_pad
            assign leaf[n] = '0;
        end
    end

    // registered minimum tree, lower index wins ties
    node_t lvl_reg [TREE_LEVELS+1][TREE_LEAVES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lvl_reg[0] <= leaf;
            for (int l = 1; l <= TREE_LEVELS; l++)
                for (int k = 0; k < (TREE_LEAVES >> l); k++)
                    lvl_reg[l][k] <= pick(lvl_reg[l-1][2*k], lvl_reg[l-1][2*k+1]);
        end
    end

    // square root, one result bit per stage
    logic [RW-1:0] srt_n_reg [QW];
    logic [RW-1:0] srt_r_reg [QW];
    node_t         srt_node_reg [QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QW; j++)
            begin
                logic [RW-1:0] n_in;
                logic [RW-1:0] r_in;
                logic [RW-1:0] bitv;
                node_t         nd_in;
                if (j == 0)
                begin
                    nd_in = lvl_reg[TREE_LEVELS][0];
                    n_in  = RW'(nd_in.sq);
                    r_in  = '0;
                end
                else
                begin
                    nd_in = srt_node_reg[j-1];
                    n_in  = srt_n_reg[j-1];
                    r_in  = srt_r_reg[j-1];
                end
                bitv = RW'(1) << (2 * (QW - 1 - j));
                if (n_in >= r_in + bitv)
                begin
                    srt_n_reg[j] <= n_in - (r_in + bitv);
                    srt_r_reg[j] <= (r_in >> 1) + bitv;
                end
                else
                begin
                    srt_n_reg[j] <= n_in;
                    srt_r_reg[j] <= r_in >> 1;
                end
                srt_node_reg[j] <= nd_in;
            end
        end
    end

    // output saturation
    node_t                 fin;
    logic [CMPW-1:0]       sq_ext;
    logic [DQW-1:0]        dist_ext;
    logic signed [DXW-1:0] dx_ext, dy_ext, dz_ext;

    assign fin      = srt_node_reg[QW-1];
    assign sq_ext   = CMPW'(fin.sq);
    assign dist_ext = DQW'(srt_r_reg[QW-1][QW-1:0]);
    assign dx_ext   = DXW'(fin.dx);
    assign dy_ext   = DXW'(fin.dy);
    assign dz_ext   = DXW'(fin.dz);

    function automatic logic signed [DISP_BITS-1:0] dsat(logic signed [DXW-1:0] v);
        if (v > DMAX)
            return DISP_BITS'(DMAX);
        else if (v < DMIN)
            return DISP_BITS'(DMIN);
        else
            return DISP_BITS'(v);
    endfunction

    logic [SQ_BITS-1:0]          sq_out_reg;
    logic [DIST_BITS-1:0]        dist_out_reg;
    logic signed [DISP_BITS-1:0] dx_out_reg, dy_out_reg, dz_out_reg;
    logic [IDX_BITS-1:0]         idx_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_out_reg   <= (sq_ext > CMPW'(SQ_MAX)) ? SQ_MAX : SQ_BITS'(sq_ext);
            dist_out_reg <= (dist_ext > DQW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(dist_ext);
            dx_out_reg   <= dsat(dx_ext);
            dy_out_reg   <= dsat(dy_ext);
            dz_out_reg   <= dsat(dz_ext);
            idx_out_reg  <= fin.idx;
        end
    end

    assign out_valid        = out_valid_reg;
    assign squared_distance = sq_out_reg;
    assign distance         = dist_out_reg;
    assign disp_x           = dx_out_reg;
    assign disp_y           = dy_out_reg;
    assign disp_z           = dz_out_reg;
    assign image_index      = idx_out_reg;

    `MIPD_ASSERT(a_idx_range, clk, rst_n, !out_valid || image_index <= IDX_MAX)
    `MIPD_ASSERT(a_root_le_sq, clk, rst_n, !out_valid || ((SQ_BITS'(distance) * SQ_BITS'(distance)) <= squared_distance))
    `MIPD_ASSERT_NEXT(a_out_load, clk, rst_n, vld_reg[NSTG-1] && en, out_valid)

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks min_image_pair_distance_core against a cycle-free predictor of the
// minimum-image search. Point pairs are sent with random bursts and gaps, and
// results are taken with random stalls. Each result is compared field by
// field with the oldest expected one. Lattice and threshold settings change
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top
    import mipd_pkg::*;
;

    localparam int CB = COORD_BITS_DEF;
    localparam int LATENCY = 12 + (2 * CB + 9) / 2;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [CB-1:0] fx, fy, fz, sx, sy, sz;
    } pair_t;

    typedef struct packed {
        logic [SQ_BITS-1:0]   sq;
        logic [DIST_BITS-1:0] root;
        logic [DISP_BITS-1:0] dx, dy, dz;
        logic [IDX_BITS-1:0]  idx;
    } dist_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [LAT_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CB-1:0] first_x = '0, first_y = '0, first_z = '0;
    logic [CB-1:0] second_x = '0, second_y = '0, second_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [SQ_BITS-1:0] squared_distance;
    logic [DIST_BITS-1:0] distance;
    logic signed [DISP_BITS-1:0] disp_x, disp_y, disp_z;
    logic [IDX_BITS-1:0] image_index;

    logic [LAT_BITS-1:0] lat_a = '0, lat_b = '0, lat_c = '0;
    logic [SQ_BITS-1:0] threshold = '0;

    pair_t pending_pairs[$];
    dist_t expected_dists[$];
    int errors = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    bit hold_off = 1'b0;
    bit drain_pause = 1'b0;
    int stall_phase = 0;

    min_image_pair_distance_core u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint coord(logic [CB-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint lat_comp(logic [LAT_BITS-1:0] r, int k);
        logic [CB-1:0] v;
        v = r[k*CB +: CB];
        return longint'(signed'(v));
    endfunction

    function automatic logic [63:0] sq_len(longint v[3]);
        logic [63:0] s;
        s = 0;
        for (int d = 0; d < 3; d++)
            s += 64'(v[d] * v[d]);
        return s;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            b = r | (64'd1 << i);
            if (b * b <= n)
                r = b;
        end
        return r;
    endfunction

    function automatic logic [DISP_BITS-1:0] sat_disp(longint v);
        if (v > DISP_LIMIT)
            v = DISP_LIMIT;
        if (v < -DISP_LIMIT - 1)
            v = -DISP_LIMIT - 1;
        return v[DISP_BITS-1:0];
    endfunction

    function automatic dist_t min_image(pair_t p);
        longint base[3], best[3], cand[3];
        logic [63:0] best_sq, t, dst;
        int n, best_n;
        bit done;
        dist_t r;
        base[0] = coord(p.fx) - coord(p.sx);
        base[1] = coord(p.fy) - coord(p.sy);
        base[2] = coord(p.fz) - coord(p.sz);
        best = base;
        best_sq = sq_len(base);
        best_n = 0;
        n = 0;
        done = 1'b0;
        if (best_sq > threshold)
            for (int aa = -1; aa <= 1; aa++)
                for (int bb = -1; bb <= 1; bb++)
                    for (int cc = -1; cc <= 1; cc++)
                    begin
                        if (!done && !(aa == 0 && bb == 0 && cc == 0))
                        begin
                            n++;
                            for (int d = 0; d < 3; d++)
                                cand[d] = base[d] + aa * lat_comp(lat_a, d)
                                    + bb * lat_comp(lat_b, d) + cc * lat_comp(lat_c, d);
                            t = sq_len(cand);
                            if (t < best_sq)
                            begin
                                best_sq = t;
                                best_n = n;
                                best = cand;
                            end
                            if (t < threshold)
                                done = 1'b1;
                        end
                    end
        dst = floor_sqrt(best_sq);
        r.sq = (best_sq > SQ_MAX) ? SQ_MAX : best_sq[SQ_BITS-1:0];
        r.root = (dst > DIST_MAX) ? DIST_MAX : dst[DIST_BITS-1:0];
        r.dx = sat_disp(best[0]);
        r.dy = sat_disp(best[1]);
        r.dz = sat_disp(best[2]);
        r.idx = best_n[IDX_BITS-1:0];
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            expected_dists.push_back(min_image({first_x, first_y, first_z,
                second_x, second_y, second_z}));
        if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready && burst_left <= 1)
            begin
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                burst_left <= $urandom_range(1, 30);
            end
            else
            begin
                if (in_valid && in_ready)
                    burst_left <= burst_left - 1;
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_pairs.size() > 0 && !drain_pause)
                begin
                    {first_x, first_y, first_z, second_x, second_y, second_z}
                        <= pending_pairs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        dist_t got, want;
        if (out_valid && out_ready)
        begin
            got = {squared_distance, distance, disp_x, disp_y, disp_z, image_index};
            if (expected_dists.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_dists.pop_front();
                if (got.sq !== want.sq)
                    $display("%0t: squared_distance exp %h got %h", $time, want.sq, got.sq);
                if (got.root !== want.root)
                    $display("%0t: distance exp %h got %h", $time, want.root, got.root);
                if (got.dx !== want.dx)
                    $display("%0t: disp_x exp %h got %h", $time, want.dx, got.dx);
                if (got.dy !== want.dy)
                    $display("%0t: disp_y exp %h got %h", $time, want.dy, got.dy);
                if (got.dz !== want.dz)
                    $display("%0t: disp_z exp %h got %h", $time, want.dz, got.dz);
                if (got.idx !== want.idx)
                    $display("%0t: image_index exp %h got %h", $time, want.idx, got.idx);
                if (got !== want)
                    errors++;
            end
        end
        stall_phase <= (stall_phase + 1) % 23;
        if (hold_off)
            out_ready <= 1'b0;
        else if (stall_phase < 8)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off
            || (!in_valid && pending_pairs.size() == 0 && expected_dists.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("min_image_pair_distance_core test failed");
            $finish;
        end
    end

    function automatic logic [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 8191) - 4096);
            default: return CB'($urandom_range(0, 65535) - 32768);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        int mode;
        mode = $urandom_range(0, 3);
        return {rand_coord(mode), rand_coord(mode), rand_coord(mode),
                rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [LAT_BITS-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LATTICE_A: lat_a = val;
            CFG_LATTICE_B: lat_b = val;
            CFG_LATTICE_C: lat_c = val;
            default: threshold = val[SQ_BITS-1:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || in_valid || expected_dists.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [LAT_BITS-1:0] pack_vec(int x, int y, int z);
        return {CB'(z), CB'(y), CB'(x)};
    endfunction

    task automatic set_cell(logic [LAT_BITS-1:0] a, logic [LAT_BITS-1:0] b,
                            logic [LAT_BITS-1:0] c, logic [SQ_BITS-1:0] th);
        wait_drained();
        write_reg(CFG_LATTICE_A, a);
        write_reg(CFG_LATTICE_B, b);
        write_reg(CFG_LATTICE_C, c);
        write_reg(CFG_THRESHOLD, th);
        @(posedge clk);
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++)
            pending_pairs.push_back(rand_pair());
    endtask

    localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    initial
    begin
        logic [LAT_BITS-1:0] a, b, c;
        logic [SQ_BITS-1:0] th;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = 5;

        // cubic cell of side 16.0, quarter of squared height as threshold
        a = pack_vec(65536, 0, 0);
        b = pack_vec(0, 65536, 0);
        c = pack_vec(0, 0, 65536);
        set_cell(a, b, c, 44'd1 << 30);
        pending_pairs.push_back({CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
        pending_pairs.push_back({CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
        pending_pairs.push_back({CB'(0), CB'(0), CB'(0), CB'(0), CB'(0), CB'(0)});
        pending_pairs.push_back({CB'(32768), CB'(0), CB'(0), CB'(0), CB'(0), CB'(0)});
        pending_pairs.push_back({CB'(32768), CB'(1), CB'(0), CB'(0), CB'(0), CB'(0)});
        pending_pairs.push_back({CB'(-32768), CB'(0), CB'(0), CB'(0), CB'(0), CB'(0)});
        pending_pairs.push_back({CB'(60000), CB'(-60000), CB'(3), CB'(0), CB'(0), CB'(0)});
        pending_pairs.push_back({CB'(-1), CB'(-1), CB'(-1), CB'(1), CB'(1), CB'(1)});
        add_random(60);

        // threshold zero: full 27-image search, ties among images
        set_cell(a, b, c, '0);
        pending_pairs.push_back({CB'(32768), CB'(0), CB'(0), CB'(0), CB'(0), CB'(0)});
        pending_pairs.push_back({CB'(32768), CB'(32768), CB'(32768), CB'(0), CB'(0), CB'(0)});
        add_random(50);

        // threshold extremes and skewed cell
        set_cell(pack_vec(40000, 5000, -3000), pack_vec(-7000, 50000, 2000),
                 pack_vec(1000, -4000, 45000), SQ_MAX);
        add_random(30);
        set_cell({LAT_BITS{1'b1}}, pack_vec(-524288, 524287, -524288),
                 pack_vec(524287, -524288, 524287), '0);
        pending_pairs.push_back({CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
        pending_pairs.push_back({CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
        add_random(40);

        // long receiver hold-off while the sender keeps offering
        set_cell(a, b, c, 44'd1 << 30);
        hold_off = 1'b1;
        add_random(80);
        repeat (300) @(posedge clk);
        hold_off = 1'b0;

        // sender pauses mid-stream until all results are back
        add_random(40);
        repeat (30) @(posedge clk);
        drain_pause = 1'b1;
        while (in_valid || expected_dists.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        drain_pause = 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            a = LAT_BITS'({$urandom, $urandom});
            b = LAT_BITS'({$urandom, $urandom});
            c = LAT_BITS'({$urandom, $urandom});
            if (ph % 2 == 0)
            begin
                a = pack_vec($urandom_range(20000, 90000), $urandom_range(0, 8000) - 4000, 0);
                b = pack_vec($urandom_range(0, 8000) - 4000, $urandom_range(20000, 90000), 0);
                c = pack_vec(0, $urandom_range(0, 8000) - 4000, $urandom_range(20000, 90000));
            end
            th = SQ_BITS'({$urandom, $urandom});
            if (ph == 1)
                th = th >> 10;
            else if (ph != 3)
                th = th >> 12;
            set_cell(a, b, c, th);
            add_random(45);
        end

        wait_drained();
        if (errors == 0)
            $display("min_image_pair_distance_core test passed");
        else
            $display("min_image_pair_distance_core test failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/mipd_pkg.sv
rtl/min_image_pair_distance_core.sv
dv/tb_top.sv
